FILE: rtl/mpl_pkg.sv
// Shared widths, codes, unit types and saturation helpers for the motor power limiter.
package mpl_pkg;

   // Field widths
   localparam int CUR_W      = 16;
   localparam int SPD_W      = 28;
   localparam int COEF_W     = 48;
   localparam int OFS_W      = 40;
   localparam int PF_W       = 17;
   localparam int PWR_W      = 48;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // Internal arithmetic: saturated terms live in +-2^61
   localparam int SUM_W  = 63;
   localparam int MAG_W  = 62;
   localparam int PROD_W = 2 * MAG_W;
   localparam int SH_W   = 6;
   localparam int CNT_W  = 6;
   localparam int WW_W   = 55;
   localparam int IW_W   = 44;
   localparam int II_W   = 31;
   localparam int B_W    = 36;

   // Square root
   localparam int ROOT_ITERATIONS = 32;
   localparam int ROOT_W     = 32;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int SREM_W     = ROOT_W + 3;
   localparam int SQRT_STEPS = (ROOT_ITERATIONS < ROOT_W) ? ROOT_ITERATIONS : ROOT_W;
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

   // Root quotients
   localparam int FRAC_SH = 23;
   localparam int NDIFF_W = B_W + 2;
   localparam int NUM_W   = NDIFF_W + FRAC_SH - 1;
   localparam int DEN_W   = COEF_W;

   localparam logic [MAG_W-1:0] LIM_MAG = MAG_W'(1) << 61;
   localparam logic signed [SUM_W:0] SUM_HI = 64'sh2000_0000_0000_0000;
   localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI;
   localparam logic [PF_W-1:0] PF_ONE = PF_W'(65536);

   // Multiplier shift amounts
   localparam logic [SH_W-1:0] SH_NONE = SH_W'(0);
   localparam logic [SH_W-1:0] SH_PF   = SH_W'(16);
   localparam logic [SH_W-1:0] SH_KC   = SH_W'(22);
   localparam logic [SH_W-1:0] SH_K2   = SH_W'(24);
   localparam logic [SH_W-1:0] SH_K0   = SH_W'(40);
   localparam logic [SH_W-1:0] SH_K1   = SH_W'(56);

   typedef enum logic [STAT_W-1:0] {
      LS_PASS   = 2'd0,
      LS_LIMIT  = 2'd1,
      LS_NOROOT = 2'd2,
      LS_K2ZERO = 2'd3
   } limit_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_CURRENT_SPEED = 3'd0,
      CSR_COEF_SPEED_SQ      = 3'd1,
      CSR_COEF_CURRENT_SQ    = 3'd2,
      CSR_POWER_OFFSET       = 3'd3,
      CSR_POWER_FACTOR       = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_WW, S_IW, S_II, S_T1, S_M0, S_M2, S_PWR, S_DEC,
      S_B, S_FP, S_BB, S_KC, S_DISC, S_SQRT, S_DIV1, S_DIV2, S_PICK, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_RUN, PH_SHIFT, PH_FIN
   } phase_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] a;
      logic [MAG_W-1:0] b;
      logic             neg;
      logic [SH_W-1:0]  shift;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [SUM_W-1:0] value;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [NUM_W:0] value;
   } div_rsp_type;

   function automatic logic signed [SUM_W-1:0] sadd(input logic signed [SUM_W-1:0] a,
                                                    input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = '0;
      s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      return s[SUM_W-1:0];
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = (v < 0) ? -v : v;
      return t[MAG_W-1:0];
   endfunction

   function automatic logic signed [PWR_W-1:0] sat_pwr(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((64'sd1 <<< (PWR_W-1)) - 64'sd1);
      lo = -SUM_W'(64'sd1 <<< (PWR_W-1));
      if (v > hi) return hi[PWR_W-1:0];
      if (v < lo) return lo[PWR_W-1:0];
      return v[PWR_W-1:0];
   endfunction

   function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [NUM_W:0] v);
      logic signed [NUM_W:0] hi;
      logic signed [NUM_W:0] lo;
      hi = (NUM_W+1)'(32767);
      lo = -(NUM_W+1)'(32768);
      if (v > hi) return hi[CUR_W-1:0];
      if (v < lo) return lo[CUR_W-1:0];
      return v[CUR_W-1:0];
   endfunction

endpackage

FILE: rtl/mpl_if.sv
// Request and response channel interfaces of the motor power limiter.
interface mpl_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mpl_pkg::CUR_W-1:0]       commanded_current;
   logic signed [mpl_pkg::SPD_W-1:0]       shaft_speed;
   modport source (output valid, commanded_current, shaft_speed, input ready);
   modport sink (input valid, commanded_current, shaft_speed, output ready);
endinterface

interface mpl_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mpl_pkg::CUR_W-1:0]       limited_current;
   logic signed [mpl_pkg::PWR_W-1:0]       est_power;
   logic [mpl_pkg::STAT_W-1:0]             limit_status;
   modport source (output valid, limited_current, est_power, limit_status, input ready);
   modport sink (input valid, limited_current, est_power, limit_status, output ready);
endinterface

FILE: rtl/motor_power_limiter_core.sv
// Top level of the motor power limiter: sequencer, square root and configuration registers.
//
// Usage
//  - req_bus carries one word: commanded current and shaft speed. It is taken
//    (valid and ready high) only while the sequencer is idle.
//  - rsp_bus carries one word per request: limited current, power estimate and
//    status. The result sits in an output register; a new request is taken
//    while it waits, and a finished word waits in the last step until the
//    output register is free, so a stalled receiver only holds up the next word.
//  - csr_* writes the five registers (index as listed in the package); write only
//    while no word is in flight. Unused indexes are ignored.
//  - Arithmetic: the work runs through one shared bit-serial multiplier and one
//    bit-serial divider. A word that passes through needs six products; a limited
//    word needs ten products, a 32-step square root and two quotients.
//  - Reset (synchronous, active high) restores the register defaults, clears the
//    last limited current and empties the output register.
module motor_power_limiter_core (
   input  logic                               clock,
   input  logic                               reset,
   mpl_req_if.sink                            req_bus,
   mpl_rsp_if.source                          rsp_bus,
   input  logic                               csr_write_enable,
   input  logic [mpl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mpl_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import mpl_pkg::*;

   // configuration
   logic signed [COEF_W-1:0] k0_ff, k1_ff, k2_ff;
   logic signed [OFS_W-1:0]  ofs_ff;
   logic [PF_W-1:0]          pf_ff;

   // sequencer
   state_type                state_ff, state_in;
   logic                     issued_ff, issued_in;
   logic signed [CUR_W-1:0]  cur_ff, cur_in;
   logic signed [SPD_W-1:0]  spd_ff, spd_in;
   logic [WW_W-1:0]          ww_ff, ww_in;
   logic signed [IW_W-1:0]   iw_ff, iw_in;
   logic [II_W-1:0]          ii_ff, ii_in;
   logic signed [SUM_W-1:0]  t1_ff, t1_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [SUM_W-1:0]  d_ff, d_in;
   logic signed [PWR_W-1:0]  p_ff, p_in;
   logic signed [B_W-1:0]    b_ff, b_in;
   logic [ROOT_W-1:0]        h_ff, h_in;
   logic signed [NUM_W:0]    r1_ff, r1_in;
   logic signed [NUM_W:0]    r2_ff, r2_in;
   logic signed [CUR_W-1:0]  last_ff, last_in;
   logic signed [CUR_W-1:0]  res_cur_ff, res_cur_in;
   limit_status_type         res_stat_ff, res_stat_in;

   // square root
   logic [RAD_W-1:0]         rad_ff, rad_in;
   logic [SREM_W-1:0]        srem_ff, srem_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [SQRT_CNT_W-1:0]    step_ff, step_in;
   logic [SREM_W-1:0]        srem_t, trial;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [CUR_W-1:0]  rsp_cur_ff, rsp_cur_in;
   logic signed [PWR_W-1:0]  rsp_pwr_ff, rsp_pwr_in;
   limit_status_type         rsp_stat_ff, rsp_stat_in;

   mul_req_type              mul_req;
   mul_rsp_type              mul_rsp;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   logic                     mul_state, div_state;
   logic signed [NDIFF_W-1:0] diff1, diff2;
   logic signed [NUM_W:0]    num1, num2, numx;
   logic signed [NUM_W:0]    m1, m2, pick;
   logic signed [SUM_W-1:0]  mv;

   mpl_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   mpl_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         k0_ff  <= '0;
         k1_ff  <= '0;
         k2_ff  <= '0;
         ofs_ff <= '0;
         pf_ff  <= PF_ONE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COEF_CURRENT_SPEED: k0_ff  <= csr_write_data[COEF_W-1:0];
            CSR_COEF_SPEED_SQ:      k1_ff  <= csr_write_data[COEF_W-1:0];
            CSR_COEF_CURRENT_SQ:    k2_ff  <= csr_write_data[COEF_W-1:0];
            CSR_POWER_OFFSET:       ofs_ff <= csr_write_data[OFS_W-1:0];
            CSR_POWER_FACTOR:       pf_ff  <= csr_write_data[PF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      spd_ff      <= spd_in;
      ww_ff       <= ww_in;
      iw_ff       <= iw_in;
      ii_ff       <= ii_in;
      t1_ff       <= t1_in;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      b_ff        <= b_in;
      h_ff        <= h_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      res_cur_ff  <= res_cur_in;
      res_stat_ff <= res_stat_in;
      rad_ff      <= rad_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      step_ff     <= step_in;
      rsp_cur_ff  <= rsp_cur_in;
      rsp_pwr_ff  <= rsp_pwr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // root numerators, (h - b) and (-b - h), scaled by 2^23
   always_comb begin
      diff1 = $signed({{(NDIFF_W-ROOT_W){1'b0}}, h_ff}) - NDIFF_W'(b_ff);
      diff2 = -NDIFF_W'(b_ff) - $signed({{(NDIFF_W-ROOT_W){1'b0}}, h_ff});
      num1  = {diff1, FRAC_SH'(0)};
      num2  = {diff2, FRAC_SH'(0)};
      numx  = (state_ff == S_DIV1) ? num1 : num2;
   end

   // root choice
   always_comb begin
      m1 = (r1_ff < 0) ? -r1_ff : r1_ff;
      m2 = (r2_ff < 0) ? -r2_ff : r2_ff;
      if ((r1_ff > 0 && r2_ff < 0) || (r1_ff < 0 && r2_ff > 0)) begin
         if ((last_ff > 0 && r1_ff > 0) || (last_ff < 0 && r1_ff < 0)) pick = r1_ff;
         else pick = r2_ff;
      end else begin
         pick = (m1 < m2) ? r1_ff : r2_ff;
      end
   end

   // one square-root digit
   always_comb begin
      srem_t = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
   end

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      cur_in       = cur_ff;
      spd_in       = spd_ff;
      ww_in        = ww_ff;
      iw_in        = iw_ff;
      ii_in        = ii_ff;
      t1_in        = t1_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      b_in         = b_ff;
      h_in         = h_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      last_in      = last_ff;
      res_cur_in   = res_cur_ff;
      res_stat_in  = res_stat_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_pwr_in   = rsp_pwr_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mul_req      = '0;
      div_req      = '0;
      mv           = mul_rsp.value;

      mul_state = state_ff inside {S_WW, S_IW, S_II, S_T1, S_M0, S_M2, S_B, S_FP, S_BB, S_KC};
      div_state = state_ff inside {S_DIV1, S_DIV2};

      // one start per unit step, cleared on completion
      if (mul_state) begin
         mul_req.start = !issued_ff;
         issued_in     = !mul_rsp.done;
      end
      if (div_state) begin
         div_req.start = !issued_ff;
         issued_in     = !div_rsp.done;
         div_req.num   = numx[NUM_W] ? NUM_W'(-numx) : numx[NUM_W-1:0];
         div_req.den   = DEN_W'((k2_ff < 0) ? -k2_ff : k2_ff);
         div_req.neg   = numx[NUM_W] ^ k2_ff[COEF_W-1];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cur_in   = req_bus.commanded_current;
               spd_in   = req_bus.shaft_speed;
               state_in = S_WW;
            end
         end
         S_WW: begin
            mul_req.a     = mag_of(SUM_W'(spd_ff));
            mul_req.b     = mag_of(SUM_W'(spd_ff));
            mul_req.shift = SH_NONE;
            if (mul_rsp.done) begin
               ww_in    = mv[WW_W-1:0];
               state_in = S_IW;
            end
         end
         S_IW: begin
            mul_req.a     = mag_of(SUM_W'(cur_ff));
            mul_req.b     = mag_of(SUM_W'(spd_ff));
            mul_req.neg   = cur_ff[CUR_W-1] ^ spd_ff[SPD_W-1];
            mul_req.shift = SH_NONE;
            if (mul_rsp.done) begin
               iw_in    = mv[IW_W-1:0];
               state_in = S_II;
            end
         end
         S_II: begin
            mul_req.a     = mag_of(SUM_W'(cur_ff));
            mul_req.b     = mag_of(SUM_W'(cur_ff));
            mul_req.shift = SH_NONE;
            if (mul_rsp.done) begin
               ii_in    = mv[II_W-1:0];
               state_in = S_T1;
            end
         end
         S_T1: begin
            mul_req.a     = mag_of(SUM_W'(k1_ff));
            mul_req.b     = MAG_W'(ww_ff);
            mul_req.neg   = k1_ff[COEF_W-1];
            mul_req.shift = SH_K1;
            if (mul_rsp.done) begin
               t1_in    = mv;
               acc_in   = mv;
               state_in = S_M0;
            end
         end
         S_M0: begin
            mul_req.a     = mag_of(SUM_W'(k0_ff));
            mul_req.b     = mag_of(SUM_W'(iw_ff));
            mul_req.neg   = k0_ff[COEF_W-1] ^ iw_ff[IW_W-1];
            mul_req.shift = SH_K0;
            if (mul_rsp.done) begin
               acc_in   = sadd(acc_ff, mv);
               state_in = S_M2;
            end
         end
         S_M2: begin
            mul_req.a     = mag_of(SUM_W'(k2_ff));
            mul_req.b     = MAG_W'(ii_ff);
            mul_req.neg   = k2_ff[COEF_W-1];
            mul_req.shift = SH_K2;
            if (mul_rsp.done) begin
               acc_in   = sadd(acc_ff, mv);
               state_in = S_PWR;
            end
         end
         S_PWR: begin
            p_in     = sat_pwr(sadd(acc_ff, SUM_W'(ofs_ff)));
            state_in = S_DEC;
         end
         S_DEC: begin
            if (p_ff > 0 && pf_ff < PF_ONE) begin
               if (k2_ff == '0) begin
                  res_cur_in  = '0;
                  res_stat_in = LS_K2ZERO;
                  last_in     = '0;
                  state_in    = S_OUT;
               end else begin
                  state_in = S_B;
               end
            end else begin
               res_cur_in  = cur_ff;
               res_stat_in = LS_PASS;
               state_in    = S_OUT;
            end
         end
         S_B: begin
            mul_req.a     = mag_of(SUM_W'(k0_ff));
            mul_req.b     = mag_of(SUM_W'(spd_ff));
            mul_req.neg   = k0_ff[COEF_W-1] ^ spd_ff[SPD_W-1];
            mul_req.shift = SH_K0;
            if (mul_rsp.done) begin
               b_in     = mv[B_W-1:0];
               acc_in   = sadd(SUM_W'(ofs_ff), t1_ff);
               state_in = S_FP;
            end
         end
         S_FP: begin
            mul_req.a     = MAG_W'(pf_ff);
            mul_req.b     = mag_of(SUM_W'(p_ff));
            mul_req.shift = SH_PF;
            if (mul_rsp.done) begin
               acc_in   = sadd(acc_ff, -mv);
               state_in = S_BB;
            end
         end
         S_BB: begin
            mul_req.a     = mag_of(SUM_W'(b_ff));
            mul_req.b     = mag_of(SUM_W'(b_ff));
            mul_req.shift = SH_NONE;
            if (mul_rsp.done) begin
               d_in     = mv;
               state_in = S_KC;
            end
         end
         S_KC: begin
            mul_req.a     = mag_of(SUM_W'(k2_ff));
            mul_req.b     = mag_of(acc_ff);
            mul_req.neg   = k2_ff[COEF_W-1] ^ acc_ff[SUM_W-1];
            mul_req.shift = SH_KC;
            if (mul_rsp.done) begin
               d_in     = sadd(d_ff, -mv);
               state_in = S_DISC;
            end
         end
         S_DISC: begin
            if (d_ff < 0) begin
               res_cur_in  = '0;
               res_stat_in = LS_NOROOT;
               last_in     = '0;
               state_in    = S_OUT;
            end else begin
               rad_in   = {1'b0, d_ff};
               srem_in  = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (srem_t >= trial) begin
               srem_in = srem_t - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = srem_t;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_in  = rad_ff << 2;
            step_in = step_ff + 1'b1;
            if (step_ff == SQRT_CNT_W'(SQRT_STEPS-1)) begin
               h_in     = root_in << (ROOT_W - SQRT_STEPS);
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               r1_in    = div_rsp.value;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               r2_in    = div_rsp.value;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            res_cur_in  = sat_cur(pick);
            res_stat_in = LS_LIMIT;
            last_in     = sat_cur(pick);
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_cur_in   = res_cur_ff;
               rsp_pwr_in   = p_ff;
               rsp_stat_in  = res_stat_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.limited_current = rsp_cur_ff;
   assign rsp_bus.est_power       = rsp_pwr_ff;
   assign rsp_bus.limit_status    = rsp_stat_ff;

endmodule

FILE: rtl/mpl_mul.sv
// Bit-serial magnitude multiplier with truncating shift and saturation to +-2^61.
module mpl_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  mpl_pkg::mul_req_type req,
   output mpl_pkg::mul_rsp_type rsp
);
   import mpl_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [PROD_W-1:0]       shifted_ff, shifted_in;
   logic [MAG_W-1:0]        acnd_ff, acnd_in;
   logic                    neg_ff, neg_in;
   logic [SH_W-1:0]         sh_ff, sh_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] value_ff, value_in;
   logic                    done_ff, done_in;
   logic [MAG_W:0]          sum;
   logic [MAG_W-1:0]        mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      shifted_ff <= shifted_in;
      acnd_ff    <= acnd_in;
      neg_ff     <= neg_in;
      sh_ff      <= sh_in;
      cnt_ff     <= cnt_in;
      value_ff   <= value_in;
   end

   always_comb begin
      phase_in   = phase_ff;
      prod_in    = prod_ff;
      shifted_in = shifted_ff;
      acnd_in    = acnd_ff;
      neg_in     = neg_ff;
      sh_in      = sh_ff;
      cnt_in     = cnt_ff;
      value_in   = value_ff;
      done_in    = 1'b0;
      sum        = '0;
      mag        = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (req.start) begin
               prod_in  = {MAG_W'(0), req.b};
               acnd_in  = req.a;
               neg_in   = req.neg;
               sh_in    = req.shift;
               cnt_in   = '0;
               phase_in = PH_RUN;
            end
         end
         PH_RUN: begin
            // shift-add, one multiplier bit per cycle
            sum     = {1'b0, prod_ff[PROD_W-1:MAG_W]} + (prod_ff[0] ? {1'b0, acnd_ff} : '0);
            prod_in = {sum, prod_ff[MAG_W-1:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W-1)) phase_in = PH_SHIFT;
         end
         PH_SHIFT: begin
            shifted_in = prod_ff >> sh_ff;
            phase_in   = PH_FIN;
         end
         PH_FIN: begin
            mag      = (shifted_ff > PROD_W'(LIM_MAG)) ? LIM_MAG : shifted_ff[MAG_W-1:0];
            value_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

FILE: rtl/mpl_div.sv
// Restoring bit-serial divider, quotient truncated toward zero.
module mpl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mpl_pkg::div_req_type req,
   output mpl_pkg::div_rsp_type rsp
);
   import mpl_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [DEN_W:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]      quo_ff, quo_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [NUM_W:0] value_ff, value_in;
   logic                  done_ff, done_in;
   logic [DEN_W:0]        trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
   end

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      value_in = value_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      case (phase_ff)
         PH_IDLE: begin
            if (req.start) begin
               rem_in   = '0;
               quo_in   = req.num;
               den_in   = req.den;
               neg_in   = req.neg;
               cnt_in   = '0;
               phase_in = PH_RUN;
            end
         end
         PH_RUN: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W-1)) phase_in = PH_FIN;
         end
         PH_FIN: begin
            value_in = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

FILE: tb/motor_power_limiter_core_tb.sv
// Self-checking testbench for the motor power limiter core: directed table, then random words.
`timescale 1ns / 1ps

module motor_power_limiter_core_tb;
   import mpl_pkg::*;

   localparam int WATCHDOG_CYCLES = 20000;
   localparam int RAND_PER_SET    = 68;
   localparam int SETS_PER_MODE   = 5;
   localparam longint LIM         = 64'sd1 <<< 61;

   typedef struct {
      logic signed [CUR_W-1:0] current;
      logic signed [PWR_W-1:0] power;
      limit_status_type        status;
   } limiter_word_type;

   // one row of the directed table; setting picks the register set in force
   typedef struct {
      int                      setting;
      logic signed [CUR_W-1:0] current;
      logic signed [SPD_W-1:0] speed;
      bit                      typed;
      limiter_word_type        want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   mpl_req_if req_bus ();
   mpl_rsp_if rsp_bus ();

   motor_power_limiter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // mirror of the register file and the kept current
   longint k_cur_spd, k_spd_sq, k_cur_sq, pwr_ofs;
   longint pwr_factor;
   longint last_current;

   limiter_word_type pending_words[$];
   int  send_idle_pct, recv_idle_pct;
   int  errors, words_sent, words_checked;
   int  status_seen[4];
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sext_val(logic [63:0] v, int w);
      logic [63:0] sgn;
      sgn = 64'd1 << (w - 1);
      v   = v & ((64'd1 << w) - 64'd1);
      return longint'(v ^ sgn) - longint'(sgn);
   endfunction

   // exact product, magnitude truncated by sh, clamped to 2^61
   function automatic longint scaled_product(longint a, longint b, int sh);
      logic [127:0] p;
      logic [63:0]  ua, ub, mag;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      p   = {64'd0, ua} * {64'd0, ub};
      p   = p >> sh;
      mag = (p > 128'(LIM)) ? LIM : p[63:0];
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clamp_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (s > LIM) return LIM;
      if (s < -LIM) return -LIM;
      return s;
   endfunction

   function automatic longint root_of(longint d);
      longint r, t;
      int     iters;
      r = 0;
      iters = (ROOT_ITERATIONS < 32) ? ROOT_ITERATIONS : 32;
      for (int k = 31; k >= 32 - iters && k >= 0; k--) begin
         t = r | (64'sd1 <<< k);
         if (t * t <= d) r = t;
      end
      return r;
   endfunction

   // power estimate and current limit for one word; updates the kept current
   function automatic limiter_word_type limit_current(logic signed [CUR_W-1:0] cmd,
                                                      logic signed [SPD_W-1:0] spd);
      limiter_word_type res;
      longint i, w, t1, p, cur, b, c, d, h, r1, r2, pick, m1, m2;
      limit_status_type st;
      i   = cmd;
      w   = spd;
      cur = i;
      st  = LS_PASS;
      t1  = scaled_product(k_spd_sq, w * w, 56);
      p   = clamp_sum(scaled_product(k_cur_spd, i * w, 40), t1);
      p   = clamp_sum(p, scaled_product(k_cur_sq, i * i, 24));
      p   = clamp_sum(p, pwr_ofs);
      if (p > (64'sd1 <<< 47) - 1) p = (64'sd1 <<< 47) - 1;
      if (p < -(64'sd1 <<< 47)) p = -(64'sd1 <<< 47);
      if (p > 0 && pwr_factor < 65536) begin
         if (k_cur_sq == 0) begin
            cur = 0;
            st  = LS_K2ZERO;
         end else begin
            b = scaled_product(k_cur_spd, w, 40);
            c = clamp_sum(clamp_sum(pwr_ofs, t1), -scaled_product(pwr_factor, p, 16));
            d = clamp_sum(scaled_product(b, b, 0), -scaled_product(k_cur_sq, c, 22));
            if (d < 0) begin
               cur = 0;
               st  = LS_NOROOT;
            end else begin
               h  = root_of(d);
               r1 = ((h - b) * 8388608) / k_cur_sq;
               r2 = ((-b - h) * 8388608) / k_cur_sq;
               if ((r1 > 0 && r2 < 0) || (r1 < 0 && r2 > 0)) begin
                  // opposite signs: follow the sign of the last limit
                  if ((last_current > 0 && r1 > 0) || (last_current < 0 && r1 < 0))
                     pick = r1;
                  else
                     pick = r2;
               end else begin
                  m1   = (r1 < 0) ? -r1 : r1;
                  m2   = (r2 < 0) ? -r2 : r2;
                  pick = (m1 < m2) ? r1 : r2;
               end
               cur = (pick > 32767) ? 32767 : (pick < -32768) ? -32768 : pick;
               st  = LS_LIMIT;
            end
         end
         last_current = cur;
      end
      res.current = cur[CUR_W-1:0];
      res.power   = p[PWR_W-1:0];
      res.status  = st;
      return res;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_COEF_CURRENT_SPEED: k_cur_spd = sext_val(value, 48);
         CSR_COEF_SPEED_SQ:      k_spd_sq  = sext_val(value, 48);
         CSR_COEF_CURRENT_SQ:    k_cur_sq  = sext_val(value, 48);
         CSR_POWER_OFFSET:       pwr_ofs   = sext_val(value, 40);
         CSR_POWER_FACTOR:       pwr_factor = value & 64'h1FFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // waits for every outstanding word, with the request side idle
   task automatic drain_words();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   task automatic load_settings(longint k0, longint k1, longint k2, longint a, longint f);
      drain_words();
      write_reg(CSR_COEF_CURRENT_SPEED, k0);
      write_reg(CSR_COEF_SPEED_SQ, k1);
      write_reg(CSR_COEF_CURRENT_SQ, k2);
      write_reg(CSR_POWER_OFFSET, a);
      write_reg(CSR_POWER_FACTOR, f);
      // out-of-range index must be ignored
      write_reg(CSR_IDX_W'($urandom_range(5, 7)), {$urandom, $urandom});
   endtask

   task automatic send_word(logic signed [CUR_W-1:0] cmd, logic signed [SPD_W-1:0] spd,
                            bit typed, limiter_word_type want);
      limiter_word_type got;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid             <= 1'b1;
      req_bus.commanded_current <= cmd;
      req_bus.shaft_speed       <= spd;
      do @(posedge clock); while (!req_bus.ready);
      got = limit_current(cmd, spd);
      pending_words.push_back(typed ? want : got);
      words_sent++;
   endtask

   function automatic longint rand_signed(int bits);
      longint v;
      v = {$urandom, $urandom};
      return v >>> (64 - bits);
   endfunction

   // receiver: ready at the falling edge, words checked at the rising edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      limiter_word_type exp_word;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word: current %0d", rsp_bus.limited_current);
            errors++;
         end else begin
            exp_word = pending_words.pop_front();
            if (rsp_bus.limited_current !== exp_word.current) begin
               $error("limited_current expected %0d got %0d",
                      exp_word.current, rsp_bus.limited_current);
               errors++;
            end
            if (rsp_bus.est_power !== exp_word.power) begin
               $error("est_power expected %0d got %0d",
                      exp_word.power, rsp_bus.est_power);
               errors++;
            end
            if (rsp_bus.limit_status !== exp_word.status) begin
               $error("limit_status expected %0d got %0d",
                      exp_word.status, rsp_bus.limit_status);
               errors++;
            end
            status_seen[exp_word.status]++;
            words_checked++;
         end
      end
   end

   // watchdog: cycles in which neither channel moves a word
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog expired with %0d words outstanding", pending_words.size());
         $display("FAILURE");
         $finish;
      end
   end

   stim_row_type stim_table[$];
   longint       set_regs[5][5];

   function automatic stim_row_type row(int s, longint cmd, longint spd, bit typed,
                                        longint wc, longint wp, limit_status_type ws);
      stim_row_type r;
      r.setting      = s;
      r.current      = cmd[CUR_W-1:0];
      r.speed        = spd[SPD_W-1:0];
      r.typed        = typed;
      r.want.current = wc[CUR_W-1:0];
      r.want.power   = wp[PWR_W-1:0];
      r.want.status  = ws;
      return r;
   endfunction

   initial begin
      int  cur_set;
      longint smax, smin;
      errors = 0; words_sent = 0; words_checked = 0; quiet_cycles = 0;
      status_seen = '{default: 0};
      send_idle_pct = 0; recv_idle_pct = 0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_bus.valid             = 1'b0;
      req_bus.commanded_current = '0;
      req_bus.shaft_speed       = '0;
      rsp_bus.ready             = 1'b0;
      k_cur_spd = 0; k_spd_sq = 0; k_cur_sq = 0; pwr_ofs = 0;
      pwr_factor = 65536; last_current = 0;

      smax = (64'sd1 <<< 47) - 1;
      smin = -(64'sd1 <<< 47);
      // register sets: defaults, k2 zero, unit k2, all extremes one way, then the other
      set_regs[0] = '{0, 0, 0, 0, 65536};
      set_regs[1] = '{0, 0, 0, 64'sd1 <<< 16, 32768};
      set_regs[2] = '{0, 0, 64'sd1 <<< 40, 0, 32768};
      set_regs[3] = '{smax, smax, smin, -(64'sd1 <<< 39), 0};
      set_regs[4] = '{smin, smin, smax, (64'sd1 <<< 39) - 1, 65535};

      // after reset: everything passes through with zero power
      stim_table.push_back(row(0, -16384, -134217728, 1, -16384, 0, LS_PASS));
      stim_table.push_back(row(0, 16384, 134217727, 1, 16384, 0, LS_PASS));
      stim_table.push_back(row(0, 0, 0, 1, 0, 0, LS_PASS));
      stim_table.push_back(row(0, -1, 1, 1, -1, 0, LS_PASS));
      // zero k2 while limiting: power is the offset alone
      stim_table.push_back(row(1, 5, 0, 1, 0, 65536, LS_K2ZERO));
      stim_table.push_back(row(1, -16384, 134217727, 1, 0, 65536, LS_K2ZERO));
      stim_table.push_back(row(1, 16384, -134217728, 1, 0, 65536, LS_K2ZERO));
      // unit k2: zero command gives no power, then limited roots of both signs
      stim_table.push_back(row(2, 0, 1000, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(2, 100, 0, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(2, -100, 0, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(2, 16384, 134217727, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(2, -16384, -134217728, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(2, 1, 65536, 0, 0, 0, LS_PASS));
      // saturating extremes
      stim_table.push_back(row(3, 16384, 134217727, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(3, -16384, 134217727, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(3, 0, -134217728, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(3, 1, 0, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(4, 16384, -134217728, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(4, -16384, -134217728, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(4, 0, 0, 0, 0, 0, LS_PASS));
      stim_table.push_back(row(4, -7, 134217727, 0, 0, 0, LS_PASS));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, no idling
      cur_set = 0;
      foreach (stim_table[n]) begin
         if (stim_table[n].setting != cur_set) begin
            cur_set = stim_table[n].setting;
            load_settings(set_regs[cur_set][0], set_regs[cur_set][1],
                          set_regs[cur_set][2], set_regs[cur_set][3],
                          set_regs[cur_set][4]);
         end
         send_word(stim_table[n].current, stim_table[n].speed,
                   stim_table[n].typed, stim_table[n].want);
      end

      // random part: three idling modes, several register sets in each
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 62 : 0;
         recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 38 : 0;
         for (int s = 0; s < SETS_PER_MODE; s++) begin
            load_settings(rand_signed($urandom_range(30, 48)),
                          rand_signed($urandom_range(20, 48)),
                          ($urandom_range(0, 7) == 0) ? 0 : rand_signed($urandom_range(30, 48)),
                          rand_signed($urandom_range(16, 40)),
                          ($urandom_range(0, 9) == 0) ? 65536 : $urandom_range(0, 65535));
            for (int n = 0; n < RAND_PER_SET; n++) begin
               limiter_word_type none;
               none.current = '0;
               none.power   = '0;
               none.status  = LS_PASS;
               // now and then hold off until the pipe is empty
               if ($urandom_range(0, 49) == 0) drain_words();
               send_word($urandom_range(0, 32768) - 16384,
                         ($urandom_range(0, 3) == 0) ? rand_signed(28)
                                                     : rand_signed($urandom_range(2, 28)),
                         0, none);
            end
         end
      end

      drain_words();
      repeat (1000) @(posedge clock);

      $display("covered %0d words over 20 register sets; status counts pass %0d limit %0d",
               words_checked, status_seen[LS_PASS], status_seen[LS_LIMIT]);
      $display("no-root %0d, k2-zero %0d, %0d field mismatches",
               status_seen[LS_NOROOT], status_seen[LS_K2ZERO], errors);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
